// ===== hdl/mdss_pkg.sv =====
// ----------------------------------------------------------------------------
// mdss_pkg
// Shared types, display codes, strobe schedule constants and the pin-order
// permutation for the multiplexed segment display scan core.
// ----------------------------------------------------------------------------
package mdss_pkg;

	localparam logic [2:0] DISP_STATUS = 3'd0;
	localparam logic [2:0] DISP_P1     = 3'd1;
	localparam logic [2:0] DISP_P2     = 3'd2;
	localparam logic [2:0] DISP_P3     = 3'd3;
	localparam logic [2:0] DISP_P4     = 3'd4;
	localparam logic [2:0] DISP_BONUS  = 3'd5;
	localparam logic [2:0] DISP_TIMER  = 3'd6;

	localparam logic [2:0] DIGITS_STATUS = 3'd4;
	localparam logic [2:0] DIGITS_PLAYER = 3'd7;
	localparam logic [2:0] DIGITS_AUX    = 3'd6;
	localparam logic [2:0] DIGIT_LAST    = 3'd6;

	localparam logic [3:0] STROBE_LAST     = 4'd15;
	localparam logic [3:0] STROBE_STATUS   = 4'd12;
	localparam logic [3:0] STROBE_HI_END   = 4'd11;
	localparam logic [3:0] STROBE_HI_START = 4'd6;
	localparam logic [3:0] STROBE_LO_END   = 4'd5;
	localparam logic [3:0] STROBE_HOLD_0   = 4'd13;
	localparam logic [3:0] STROBE_HOLD_1   = 4'd14;

	localparam int BANK_AB_DEPTH = 16;
	localparam int BANK_C_DEPTH  = 24;

	// bank C regions: status, bonus, timer
	localparam logic [1:0] REG_STATUS = 2'd0;
	localparam logic [1:0] REG_BONUS  = 2'd1;
	localparam logic [1:0] REG_TIMER  = 2'd2;

	typedef struct packed {
		logic wr;
		logic tick;
		logic rd;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic mode;
	} status_t;

	// input a c e g h f d b (bit7..0) to pin order a b c d e f g h (bit0..7)
	function automatic logic [7:0] to_pins(input logic [7:0] v);
		return {v[3], v[4], v[2], v[5], v[1], v[6], v[0], v[7]};
	endfunction

endpackage

// ===== hdl/mdss_in_if.sv =====
// ----------------------------------------------------------------------------
// mdss_in_if
// Item channel: segment writes and scan ticks.
// ----------------------------------------------------------------------------
interface mdss_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [2:0] display_select;
	logic [2:0] digit_index;
	logic [7:0] segment_bits;

	modport source (output valid, output operation, output display_select,
		output digit_index, output segment_bits, input ready);
	modport sink (input valid, input operation, input display_select,
		input digit_index, input segment_bits, output ready);
endinterface

// ===== hdl/mdss_out_if.sv =====
// ----------------------------------------------------------------------------
// mdss_out_if
// Result channel: three pin group bytes and the active strobe.
// ----------------------------------------------------------------------------
interface mdss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] group_a;
	logic [7:0] group_b;
	logic [7:0] group_c;
	logic [3:0] strobe_index;

	modport source (output valid, output group_a, output group_b, output group_c,
		output strobe_index, input ready);
	modport sink (input valid, input group_a, input group_b, input group_c,
		input strobe_index, output ready);
endinterface

// ===== hdl/mdss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mdss_cfg_if
// Configuration write channel for the mode_80b register.
// ----------------------------------------------------------------------------
interface mdss_cfg_if;
	logic valid;
	logic ready;
	logic mode_80b;

	modport source (output valid, output mode_80b, input ready);
	modport sink (input valid, input mode_80b, output ready);
endinterface

// ===== hdl/multiplexed_segment_display_scan_core.sv =====
// ----------------------------------------------------------------------------
// multiplexed_segment_display_scan_core
// Segment store and strobe sequencer for a seven-display multiplexed panel.
// ----------------------------------------------------------------------------
// Channels: item (sink) carries segment writes (operation 0) and scan ticks
// (operation 1); result (source) carries group_a/b/c in pin order a..h and
// strobe_index; cfg (sink) writes mode_80b and is always ready.
// A write updates the store at the edge that accepts it; out of range
// digits and display seven are dropped. A tick advances the strobe counter
// at acceptance, reads the three store banks in the next cycle and loads the
// result register in its load step once any pending result is taken. item
// is not ready during the read and load steps, so a new tick waits until the
// last has loaded; writes are taken one per cycle while no tick is busy.
// With mode_80b set a tick only advances the strobe counter, with no result.
// The result register parts the two sides: writes and one further tick are
// taken while a result waits; that tick then holds in its load step until
// the receiver takes the pending transfer.
// Reset clears the store through per-entry valid bits at once, sets the
// strobe counter to 15, the groups to zero and mode_80b to zero.
// ----------------------------------------------------------------------------
module multiplexed_segment_display_scan_core (
	input logic        clk,
	input logic        arst_n,
	mdss_in_if.sink    item,
	mdss_out_if.source result,
	mdss_cfg_if.sink   cfg
);

	mdss_pkg::cmd_t    cmd;
	mdss_pkg::status_t status;

	assign cfg.ready = 1'b1;

	mdss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.operation),
		.item_ready (item.ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.status     (status),
		.cmd        (cmd)
	);

	mdss_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg.valid),
		.cfg_mode       (cfg.mode_80b),
		.display_select (item.display_select),
		.digit_index    (item.digit_index),
		.segment_bits   (item.segment_bits),
		.cmd            (cmd),
		.status         (status),
		.group_a        (result.group_a),
		.group_b        (result.group_b),
		.group_c        (result.group_c),
		.strobe_index   (result.strobe_index)
	);

endmodule

// ===== hdl/mdss_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdss_ctrl
// Sequencer: accepts items, steps a tick through store read and group load,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module mdss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_op,
	output logic              item_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mdss_pkg::status_t status,
	output mdss_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       acc;

	assign item_ready = (state_q == S_IDLE);
	assign acc        = item_valid && item_ready;
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd.wr   = acc && !item_op;
		cmd.tick = acc && item_op;
		cmd.rd   = (state_q == S_READ);
		cmd.load = (state_q == S_LOAD) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && item_op && !status.mode) state_d = S_READ;
			end
			S_READ: state_d = S_LOAD;
			S_LOAD: begin
				if (cmd.load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_tick_reads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick && !status.mode |=> state_q == S_READ)
		else $error("tick with scan enabled did not start a read");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("load overwrote a pending result");

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> state_q == S_LOAD && !cmd.rd)
		else $error("read not followed by load");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ || state_q == S_LOAD) |-> !cmd.wr && !cmd.tick)
		else $error("item accepted during a tick");

endmodule

// ===== hdl/mdss_dp.sv =====
// ----------------------------------------------------------------------------
// mdss_dp
// Datapath: banked segment store, strobe counter, mode register and the
// pin group latches that form the result register.
// ----------------------------------------------------------------------------
module mdss_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_mode,
	input  logic [2:0]        display_select,
	input  logic [2:0]        digit_index,
	input  logic [7:0]        segment_bits,
	input  mdss_pkg::cmd_t    cmd,
	output mdss_pkg::status_t status,
	output logic [7:0]        group_a,
	output logic [7:0]        group_b,
	output logic [7:0]        group_c,
	output logic [3:0]        strobe_index
);

	localparam int AB_W = $clog2(mdss_pkg::BANK_AB_DEPTH);
	localparam int C_W  = $clog2(mdss_pkg::BANK_C_DEPTH);

	logic [7:0] mem_a [mdss_pkg::BANK_AB_DEPTH];
	logic [7:0] mem_b [mdss_pkg::BANK_AB_DEPTH];
	logic [7:0] mem_c [mdss_pkg::BANK_C_DEPTH];

	logic [mdss_pkg::BANK_AB_DEPTH-1:0] va_q;
	logic [mdss_pkg::BANK_AB_DEPTH-1:0] vb_q;
	logic [mdss_pkg::BANK_C_DEPTH-1:0]  vc_q;

	logic       mode_q;
	logic [3:0] strobe_q;

	logic            wr_a, wr_b, wr_c;
	logic [AB_W-1:0] wa_ab;
	logic [C_W-1:0]  wa_c;

	logic [AB_W-1:0] ra_ab;
	logic [C_W-1:0]  ra_c;
	logic            hold_ab;
	logic [3:0]      s_hi;

	logic [7:0] rd_a_s1, rd_b_s1, rd_c_s1;
	logic       rv_a_s1, rv_b_s1, rv_c_s1;
	logic       hold_ab_s1;
	logic [3:0] strobe_s1;

	logic [7:0] grp_a_q, grp_b_q, grp_c_q;
	logic [3:0] strobe_out_q;

	assign status.mode = mode_q;

	always_comb begin
		wr_a  = 1'b0;
		wr_b  = 1'b0;
		wr_c  = 1'b0;
		wa_ab = {(display_select == mdss_pkg::DISP_P2 ||
			display_select == mdss_pkg::DISP_P4), digit_index};
		wa_c  = {mdss_pkg::REG_STATUS, digit_index};
		unique case (display_select) inside
			mdss_pkg::DISP_STATUS: begin
				wr_c = digit_index < mdss_pkg::DIGITS_STATUS;
			end
			mdss_pkg::DISP_P1, mdss_pkg::DISP_P2: begin
				wr_a = digit_index < mdss_pkg::DIGITS_PLAYER;
			end
			mdss_pkg::DISP_P3, mdss_pkg::DISP_P4: begin
				wr_b = digit_index < mdss_pkg::DIGITS_PLAYER;
			end
			mdss_pkg::DISP_BONUS: begin
				wr_c = digit_index < mdss_pkg::DIGITS_AUX;
				wa_c = {mdss_pkg::REG_BONUS, digit_index};
			end
			mdss_pkg::DISP_TIMER: begin
				wr_c = digit_index < mdss_pkg::DIGITS_AUX;
				wa_c = {mdss_pkg::REG_TIMER, digit_index};
			end
			default: ;
		endcase
	end

	always_comb begin
		s_hi    = strobe_q - mdss_pkg::STROBE_HI_START;
		hold_ab = 1'b0;
		if (strobe_q <= mdss_pkg::STROBE_LO_END) begin
			ra_ab = {1'b0, strobe_q[2:0]};
			ra_c  = {mdss_pkg::REG_BONUS, strobe_q[2:0]};
		end else if (strobe_q <= mdss_pkg::STROBE_HI_END) begin
			ra_ab = {1'b1, s_hi[2:0]};
			ra_c  = {mdss_pkg::REG_TIMER, s_hi[2:0]};
		end else begin
			ra_ab   = {(strobe_q == mdss_pkg::STROBE_STATUS), mdss_pkg::DIGIT_LAST};
			ra_c    = {mdss_pkg::REG_STATUS, 1'b0, strobe_q[1:0]};
			hold_ab = (strobe_q == mdss_pkg::STROBE_HOLD_0) ||
				(strobe_q == mdss_pkg::STROBE_HOLD_1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			strobe_q <= mdss_pkg::STROBE_LAST;
			va_q     <= '0;
			vb_q     <= '0;
			vc_q     <= '0;
		end else begin
			if (cfg_valid) mode_q <= cfg_mode;
			if (cmd.tick) strobe_q <= strobe_q + 4'd1;
			if (cmd.wr && wr_a) va_q[wa_ab] <= 1'b1;
			if (cmd.wr && wr_b) vb_q[wa_ab] <= 1'b1;
			if (cmd.wr && wr_c) vc_q[wa_c] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_a) mem_a[wa_ab] <= segment_bits;
		if (cmd.wr && wr_b) mem_b[wa_ab] <= segment_bits;
		if (cmd.wr && wr_c) mem_c[wa_c] <= segment_bits;
		if (cmd.rd) begin
			rd_a_s1    <= mem_a[ra_ab];
			rd_b_s1    <= mem_b[ra_ab];
			rd_c_s1    <= mem_c[ra_c];
			rv_a_s1    <= va_q[ra_ab];
			rv_b_s1    <= vb_q[ra_ab];
			rv_c_s1    <= vc_q[ra_c];
			hold_ab_s1 <= hold_ab;
			strobe_s1  <= strobe_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_a_q <= '0;
			grp_b_q <= '0;
			grp_c_q <= '0;
		end else if (cmd.load) begin
			if (!hold_ab_s1) begin
				grp_a_q <= mdss_pkg::to_pins(rv_a_s1 ? rd_a_s1 : 8'h00);
				grp_b_q <= mdss_pkg::to_pins(rv_b_s1 ? rd_b_s1 : 8'h00);
			end
			grp_c_q <= mdss_pkg::to_pins(rv_c_s1 ? rd_c_s1 : 8'h00);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) strobe_out_q <= strobe_s1;
	end

	assign group_a      = grp_a_q;
	assign group_b      = grp_b_q;
	assign group_c      = grp_c_q;
	assign strobe_index = strobe_out_q;

	a_strobe_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> strobe_q == $past(strobe_q) + 4'd1)
		else $error("strobe counter did not advance by one");

	a_hold_ab: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && hold_ab_s1 |=> $stable(grp_a_q) && $stable(grp_b_q))
		else $error("groups A and B changed on a hold strobe");

	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({wr_a, wr_b, wr_c}))
		else $error("write decoded to more than one bank");

endmodule

// ===== tb/mdss_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// mdss_tb_pkg
// Operation codes that both the stimulus and the checker of the segment display
// scan testbench use, and the out-of-range display code that the stimulus sends.
// ----------------------------------------------------------------------------
package mdss_tb_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [2:0] DISP_NONE = 3'd7;

endpackage

// ===== tb/mdss_scan_checker.sv =====
// ----------------------------------------------------------------------------
// mdss_scan_checker
// Watches the item, config and result channels of the scan core, keeps its own
// copy of the segment store, strobe counter and group latches, and checks
// every result transfer against the oldest predicted scan frame.
// ----------------------------------------------------------------------------
module mdss_scan_checker (
	input  logic clk,
	input  logic arst_n,
	mdss_in_if   item,
	mdss_out_if  result,
	mdss_cfg_if  cfg,
	output int   failures,
	output int   outstanding
);
	import mdss_pkg::*;
	import mdss_tb_pkg::*;

	typedef struct packed {
		logic [7:0] group_a;
		logic [7:0] group_b;
		logic [7:0] group_c;
		logic [3:0] strobe_index;
	} scan_frame_t;

	// source bit of each pin, pin 0 in the low three bits
	localparam logic [23:0] PIN_SRC = {3'd3, 3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd0, 3'd7};

	logic [7:0]  segment_mem [0:55];
	logic [3:0]  strobe_ctr;
	logic [3:0]  strobe_rel;
	logic [7:0]  latch_a;
	logic [7:0]  latch_b;
	logic [7:0]  latch_c;
	logic        scan_off;
	scan_frame_t frames_due [$];
	scan_frame_t want;
	scan_frame_t got;
	int          reports;

	function automatic logic [7:0] pin_order(input logic [7:0] v);
		logic [7:0] p;
		for (int k = 0; k < 8; k++)
			p[k] = v[PIN_SRC[3*k +: 3]];
		return p;
	endfunction

	function automatic int digits_of(input logic [2:0] disp);
		case (disp)
			DISP_STATUS: return DIGITS_STATUS;
			DISP_P1, DISP_P2, DISP_P3, DISP_P4: return DIGITS_PLAYER;
			DISP_BONUS, DISP_TIMER: return DIGITS_AUX;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] slot_pins(input logic [2:0] disp, input logic [2:0] digit);
		return pin_order(segment_mem[{disp, digit}]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 56; i++)
				segment_mem[i] = '0;
			strobe_ctr = STROBE_LAST;
			latch_a = '0;
			latch_b = '0;
			latch_c = '0;
			scan_off = 1'b0;
			frames_due.delete();
			failures = 0;
			reports = 0;
			outstanding = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = {result.group_a, result.group_b, result.group_c, result.strobe_index};
				if (frames_due.size() == 0) begin
					failures++;
					if (reports < 10)
						$display("unexpected scan frame: a=%h b=%h c=%h strobe=%0d",
							got.group_a, got.group_b, got.group_c, got.strobe_index);
					reports++;
				end else begin
					want = frames_due.pop_front();
					if (got !== want) begin
						failures++;
						if (reports < 10)
							$display("scan frame mismatch: expected a=%h b=%h c=%h strobe=%0d, got a=%h b=%h c=%h strobe=%0d",
								want.group_a, want.group_b, want.group_c, want.strobe_index,
								got.group_a, got.group_b, got.group_c, got.strobe_index);
						reports++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				scan_off = cfg.mode_80b;
			if (item.valid && item.ready) begin
				if (item.operation == OP_WRITE) begin
					if (item.digit_index < digits_of(item.display_select))
						segment_mem[{item.display_select, item.digit_index}] = item.segment_bits;
				end else begin
					strobe_ctr = strobe_ctr + 4'd1;
					if (!scan_off) begin
						if (strobe_ctr <= STROBE_LO_END) begin
							latch_a = slot_pins(DISP_P1, strobe_ctr[2:0]);
							latch_b = slot_pins(DISP_P3, strobe_ctr[2:0]);
							latch_c = slot_pins(DISP_BONUS, strobe_ctr[2:0]);
						end else if (strobe_ctr <= STROBE_HI_END) begin
							strobe_rel = strobe_ctr - STROBE_HI_START;
							latch_a = slot_pins(DISP_P2, strobe_rel[2:0]);
							latch_b = slot_pins(DISP_P4, strobe_rel[2:0]);
							latch_c = slot_pins(DISP_TIMER, strobe_rel[2:0]);
						end else begin
							if (strobe_ctr == STROBE_STATUS) begin
								latch_a = slot_pins(DISP_P2, DIGIT_LAST);
								latch_b = slot_pins(DISP_P4, DIGIT_LAST);
							end
							if (strobe_ctr == STROBE_LAST) begin
								latch_a = slot_pins(DISP_P1, DIGIT_LAST);
								latch_b = slot_pins(DISP_P3, DIGIT_LAST);
							end
							strobe_rel = strobe_ctr - STROBE_STATUS;
							latch_c = slot_pins(DISP_STATUS, strobe_rel[2:0]);
						end
						frames_due.push_back({latch_a, latch_b, latch_c, strobe_ctr});
					end
				end
			end
			outstanding = frames_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives segment writes, scan ticks and mode changes into the scan core with
// random gaps and result stalls; a checker beside the core predicts every
// scan frame and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import mdss_pkg::*;
	import mdss_tb_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet = 1'b0;
	int   failures;
	int   outstanding;
	int   cycle_count = 0;

	mdss_in_if  item_ch ();
	mdss_out_if result_ch ();
	mdss_cfg_if cfg_ch ();

	multiplexed_segment_display_scan_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	mdss_scan_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ch.ready <= quiet || ($urandom_range(99) >= 13);
	end

	task automatic send_item(input logic op, input logic [2:0] disp, input logic [2:0] digit,
		input logic [7:0] seg);
		while (!quiet && $urandom_range(99) < 13) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.display_select <= disp;
		item_ch.digit_index <= digit;
		item_ch.segment_bits <= seg;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic scan_tick();
		send_item(OP_TICK, 3'($urandom_range(7)), 3'($urandom_range(7)), 8'($urandom_range(255)));
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_scan_mode(input logic off);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.mode_80b <= off;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [2:0] pick_digit(input logic [2:0] disp);
		case (disp)
			DISP_STATUS: return 3'($urandom_range(DIGITS_STATUS - 1));
			DISP_BONUS, DISP_TIMER: return 3'($urandom_range(DIGITS_AUX - 1));
			default: return 3'($urandom_range(DIGITS_PLAYER - 1));
		endcase
	endfunction

	task automatic random_traffic(input int count);
		int         sent;
		int         roll;
		logic [2:0] disp;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				scan_tick();
				sent++;
			end else if (roll < 88) begin
				disp = 3'($urandom_range(DISP_TIMER));
				send_item(OP_WRITE, disp, pick_digit(disp), 8'($urandom_range(255)));
				sent++;
			end else begin
				// drop-path noise: any display, any digit
				send_item(OP_WRITE, 3'($urandom_range(7)), 3'($urandom_range(7)),
					8'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_WRITE;
		item_ch.display_select = DISP_STATUS;
		item_ch.digit_index = 3'd0;
		item_ch.segment_bits = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.mode_80b = 1'b0;
		result_ch.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_scan_mode(1'b0);
		scan_tick();
		send_item(OP_WRITE, DISP_P1, 3'd0, 8'hFF);
		send_item(OP_WRITE, DISP_P3, 3'd0, 8'h80);
		send_item(OP_WRITE, DISP_BONUS, 3'd5, 8'h01);
		send_item(OP_WRITE, DISP_STATUS, 3'd3, 8'hA5);
		send_item(OP_WRITE, DISP_P4, DIGIT_LAST, 8'h3C);
		send_item(OP_WRITE, DISP_P1, DIGIT_LAST, 8'h96);
		send_item(OP_WRITE, DISP_STATUS, 3'd4, 8'hEE);
		send_item(OP_WRITE, DISP_BONUS, 3'd6, 8'hEE);
		send_item(OP_WRITE, DISP_TIMER, 3'd7, 8'hEE);
		send_item(OP_WRITE, DISP_P2, 3'd7, 8'hEE);
		send_item(OP_WRITE, DISP_NONE, 3'd0, 8'hEE);
		repeat (16) scan_tick();

		random_traffic(550);
		set_scan_mode(1'b1);
		random_traffic(250);
		set_scan_mode(1'b0);
		quiet = 1'b1;
		random_traffic(450);
		settle();
		quiet = 1'b0;
		set_scan_mode(1'b1);
		random_traffic(150);
		set_scan_mode(1'b0);
		random_traffic(420);

		settle();
		repeat (10) @(negedge clk);
		if (failures == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
